@@ design/insertion_sorter_defines.svh @@
// Assertion macros used by the insertion sorter checker.
`ifndef INSERTION_SORTER_DEFINES_SVH
`define INSERTION_SORTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ISORT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("insertion_sorter: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ISORT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("insertion_sorter: next-cycle check failed");

`endif

@@ design/isort_pkg.sv @@
// Types and constants shared by the insertion sorter and its checker.
package isort_pkg;

    localparam int MAX_KEYS_DEF = 16;
    localparam int KEY_W        = 32;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic                    final_key;
    } in_item_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] sorted_key;
        logic                    end_of_set;
        logic                    overflow;
    } out_item_t;

endpackage

@@ design/insertion_sorter.sv @@
// Stable insertion sorter for sets of signed keys, built around one key memory.
//
// Keys arrive one item at a time; the item with final_key set closes a set.
// Each key is placed into a sorted memory of MAX_KEYS entries by moving every
// strictly larger stored key up one place, so equal keys keep their arrival
// order. The memory has one write port and one synchronous read port, and the
// shift walks down from the top of the filled region at one entry per cycle:
// a key that lands below stored keys keeps the input closed until every larger
// key has moved up and the key is written, while a key into an empty or full
// store leaves the input open. When the set is closed, every stored key is sent
// out in ascending order through an output register, each read from memory in
// ST_EMIT and loaded in ST_LOAD, with end_of_set on the last one. Keys that
// arrive while the store is full are dropped, and every result of that set then
// carries overflow. A new set may start while the final result of the previous
// one still waits in the output register. No clearing pass follows reset; only
// written entries are ever read.
module insertion_sorter #(
    parameter int MAX_KEYS = isort_pkg::MAX_KEYS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  isort_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output isort_pkg::out_item_t out_data
);
    import isort_pkg::*;

    localparam int IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CNT_W = $clog2(MAX_KEYS + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SHIFT = 3'd1;
    localparam logic [2:0] ST_PLACE = 3'd2;
    localparam logic [2:0] ST_EMIT  = 3'd3;
    localparam logic [2:0] ST_LOAD  = 3'd4;

    // Sorted key memory: one write and one registered read per cycle.
    logic signed [KEY_W-1:0] key_mem [MAX_KEYS];
    logic signed [KEY_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic signed [KEY_W-1:0] wr_data;

    logic [2:0]              state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic [IDX_W-1:0]        emit_idx_reg, emit_idx_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic                    final_reg, final_next;
    logic                    dropped_reg, dropped_next;
    logic                    out_valid_reg, out_valid_next;
    out_item_t               out_data_reg, out_data_next;

    logic in_fire;
    logic store_full;
    logic emit_last;

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign store_full = (count_reg == CNT_W'(MAX_KEYS));
    assign emit_last  = ((CNT_W'(emit_idx_reg) + CNT_W'(1)) == count_reg);
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= key_mem[rd_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        emit_idx_next  = emit_idx_reg;
        key_next       = key_reg;
        final_next     = final_reg;
        dropped_next   = dropped_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = key_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    key_next      = in_data.key;
                    final_next    = in_data.final_key;
                    emit_idx_next = '0;
                    if (store_full)
                    begin
                        dropped_next = 1'b1;
                        state_next   = in_data.final_key ? ST_EMIT : ST_IDLE;
                    end
                    else if (count_reg == '0)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        wr_data    = in_data.key;
                        count_next = CNT_W'(1);
                        state_next = in_data.final_key ? ST_EMIT : ST_IDLE;
                    end
                    else
                    begin
                        pos_next   = count_reg[IDX_W-1:0];
                        rd_addr    = count_reg[IDX_W-1:0] - IDX_W'(1);
                        state_next = ST_SHIFT;
                    end
                end
            end

            ST_SHIFT:
            begin
                // rd_data_reg holds the entry just below the gap at pos_reg.
                wr_en   = 1'b1;
                wr_addr = pos_reg;
                if (rd_data_reg > key_reg)
                begin
                    wr_data  = rd_data_reg;
                    pos_next = pos_reg - IDX_W'(1);
                    if (pos_reg == IDX_W'(1))
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        rd_addr = pos_reg - IDX_W'(2);
                    end
                end
                else
                begin
                    wr_data    = key_reg;
                    count_next = count_reg + CNT_W'(1);
                    state_next = final_reg ? ST_EMIT : ST_IDLE;
                end
            end

            ST_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = key_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = final_reg ? ST_EMIT : ST_IDLE;
            end

            ST_EMIT:
            begin
                // Read the next key only once the output register will be free.
                if (!out_valid_reg || out_ready)
                begin
                    rd_addr    = emit_idx_reg;
                    state_next = ST_LOAD;
                end
            end

            ST_LOAD:
            begin
                out_valid_next           = 1'b1;
                out_data_next.sorted_key = rd_data_reg;
                out_data_next.end_of_set = emit_last;
                out_data_next.overflow   = dropped_reg;
                if (emit_last)
                begin
                    count_next   = '0;
                    dropped_next = 1'b0;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    emit_idx_next = emit_idx_reg + IDX_W'(1);
                    state_next    = ST_EMIT;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pos_reg       <= '0;
            emit_idx_reg  <= '0;
            final_reg     <= 1'b0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            emit_idx_reg  <= emit_idx_next;
            final_reg     <= final_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        out_data_reg <= out_data_next;
    end

endmodule

@@ design/isort_checker.sv @@
// Port-level checker for the insertion sorter, bound into every insertion_sorter instance.
`include "insertion_sorter_defines.svh"

module isort_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input isort_pkg::out_item_t out_data
);
    import isort_pkg::*;

    // While a set is still being sent out, no new key may be taken.
    `ISORT_ASSERT_SAME(a_no_input_mid_set, clk, rst_n, out_valid && !out_data.end_of_set, !in_ready)

    // Taking a result that is not the last keeps the input closed next cycle.
    `ISORT_ASSERT_NEXT(a_closed_after_mid, clk, rst_n, out_valid && out_ready && !out_data.end_of_set, !in_ready)

    // A stalled result stays valid.
    `ISORT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // A stalled result keeps its payload.
    `ISORT_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_data))

endmodule

bind insertion_sorter isort_checker u_isort_checker (.*);
